// ----- sv/mualm_pkg.sv -----
// Shared constants and types for the multi-user wakeup alarm clock.
package mualm_pkg;

  localparam int NUM_ALARMS_DEF    = 8;
  localparam int MS_PER_SECOND_DEF = 1000;

  localparam int MODE_W    = 3;
  localparam int USER_W    = 6;
  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int MS_W      = 16;
  localparam int PERIOD_W  = 10;
  localparam int INUSE_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int MAP_W     = 64;
  localparam int UID_W     = 8;

  localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET_REL    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET_ABS    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ABORT      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SET_CLOCK  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GET_CLOCK  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_GET_WAKEUP = 3'd6;
  localparam logic [MODE_W-1:0] MODE_CANCEL_ALL = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_OK   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EARLIER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PAST     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNINIT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_USER = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_MANAGER_READY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_USER_MAP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARMS_IN_USE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_CLOCK_ALLOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD     = 3'd4;

  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 10'd10;
  localparam logic [TIME_W-1:0]   TIME_ALL_ONES   = '1;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] retiring;
  } scan_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] best;
  } scan_rsp_t;

endpackage

// ----- sv/multi_user_wakeup_alarm_clock_top.sv -----
// Top level of the multi-user wakeup alarm clock: control, state and result register.
//
// Usage: items enter on the in_ channel (mode, user, time_value) with a valid/ready
// handshake; each item yields exactly one result item on the out_ channel (status,
// time_out, alarm_fired). Registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the block is idle; the block does not enforce it.
// The alarm slots live in a small RAM; a valid bit per slot stands for the zero value
// after reset and after cancel all. An accepted item is worked in the execute state and
// its result is loaded into the result register from the done state; an abort first
// reads its slot in an evaluate state. A tick that fires and an abort of the master alarm
// walk all slots through the RAM read port, one per cycle, before the done state.
// One item is worked on at a time; a new item is accepted only while the block is idle.
// The result register holds a finished result while the receiver stalls; the next
// item is accepted meanwhile and waits for the register before its result is loaded.
// Reset is synchronous; it clears the clock, the millisecond count and the slot valid
// bits, sets the master alarm to all ones and loads the register reset values.
module multi_user_wakeup_alarm_clock_top #(
  parameter int NUM_ALARMS    = mualm_pkg::NUM_ALARMS_DEF,
  parameter int MS_PER_SECOND = mualm_pkg::MS_PER_SECOND_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mualm_pkg::MODE_W-1:0]       in_mode,
  input  logic [mualm_pkg::USER_W-1:0]       in_user,
  input  logic [mualm_pkg::TIME_W-1:0]       in_time_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mualm_pkg::STATUS_W-1:0]     out_status,
  output logic [mualm_pkg::TIME_W-1:0]       out_time_out,
  output logic                               out_alarm_fired,
  input  logic                               cfg_we,
  input  logic [mualm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mualm_pkg::CFG_W-1:0]        cfg_wdata
);
  import mualm_pkg::*;

  localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int ACC_W = MS_W + 1;

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_EXEC       = 3'd1;
  localparam logic [2:0] S_ABORT_EVAL = 3'd2;
  localparam logic [2:0] S_SCAN       = 3'd3;
  localparam logic [2:0] S_DONE       = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic                ready_r;
  logic [MAP_W-1:0]    map_r;
  logic [INUSE_W-1:0]  in_use_r;
  logic [MAP_W-1:0]    allowed_r;
  logic [PERIOD_W-1:0] period_r;

  logic [MODE_W-1:0] mode_r;
  logic [USER_W-1:0] user_r;
  logic [TIME_W-1:0] tv_r;

  logic [TIME_W-1:0]     clock_r, clock_nxt;
  logic [TIME_W-1:0]     master_r, master_nxt;
  logic [MS_W-1:0]       ms_r, ms_nxt;
  logic [NUM_ALARMS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]      slot_r, slot_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [TIME_W-1:0]   res_time_r, res_time_nxt;
  logic                res_fired_r, res_fired_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [TIME_W-1:0]   out_time_r;
  logic                out_fired_r;
  logic                out_load;

  logic [INUSE_W-1:0] limit;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [ACC_W-1:0]   acc;
  logic [TIME_W-1:0]  clock_inc;
  logic [TIME_W-1:0]  rel_time;
  logic [TIME_W-1:0]  slot_value;

  logic              ram_we;
  logic [TIME_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [TIME_W-1:0] ram_rdata;
  logic              abort_re;

  scan_req_t        scan_req;
  scan_rsp_t        scan_rsp;
  logic             scan_re;
  logic [IDX_W-1:0] scan_addr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r   <= 1'b0;
      map_r     <= '0;
      in_use_r  <= '0;
      allowed_r <= '0;
      period_r  <= TICK_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MANAGER_READY:   ready_r   <= cfg_wdata[0];
        CFG_ALARM_USER_MAP:  map_r     <= cfg_wdata[MAP_W-1:0];
        CFG_ALARMS_IN_USE:   in_use_r  <= cfg_wdata[INUSE_W-1:0];
        CFG_SET_CLOCK_ALLOW: allowed_r <= cfg_wdata[MAP_W-1:0];
        CFG_TICK_PERIOD:     period_r  <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // The lowest configured slot whose owner byte matches the user.
  assign limit = (in_use_r > INUSE_W'(NUM_ALARMS)) ? INUSE_W'(NUM_ALARMS) : in_use_r;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_ALARMS - 1; i >= 0; i--) begin
      if (INUSE_W'(i) < limit && map_r[UID_W*i +: UID_W] == UID_W'(user_r)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign acc        = ACC_W'(ms_r) + ACC_W'(period_r);
  assign clock_inc  = clock_r + 1'b1;
  assign rel_time   = clock_r + tv_r;
  assign slot_value = valid_r[slot_r] ? ram_rdata : '0;
  assign out_load   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    clock_nxt      = clock_r;
    master_nxt     = master_r;
    ms_nxt         = ms_r;
    valid_nxt      = valid_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_time_nxt   = res_time_r;
    res_fired_nxt  = res_fired_r;
    ram_we         = 1'b0;
    ram_wdata      = rel_time;
    abort_re       = 1'b0;
    scan_req.start    = 1'b0;
    scan_req.retiring = master_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_nxt = ST_OK;
        res_time_nxt   = '0;
        res_fired_nxt  = 1'b0;
        slot_nxt       = hit_idx;
        state_nxt      = S_DONE;
        if (!ready_r) begin
          res_status_nxt = ST_UNINIT;
        end else begin
          case (mode_r) inside
            MODE_TICK: begin
              if (acc >= ACC_W'(MS_PER_SECOND)) begin
                ms_nxt    = '0;
                clock_nxt = clock_inc;
                if (clock_inc >= master_r) begin
                  res_fired_nxt  = 1'b1;
                  scan_req.start = 1'b1;
                  state_nxt      = S_SCAN;
                end
              end else begin
                ms_nxt = acc[MS_W-1:0];
              end
            end
            MODE_SET_REL, MODE_SET_ABS: begin
              ram_wdata = (mode_r == MODE_SET_REL) ? rel_time : tv_r;
              if (!hit) begin
                res_status_nxt = ST_BAD_USER;
              end else if (mode_r == MODE_SET_ABS && tv_r <= clock_r) begin
                res_status_nxt = ST_PAST;
              end else begin
                ram_we             = 1'b1;
                valid_nxt[hit_idx] = 1'b1;
                if (ram_wdata < master_r) begin
                  master_nxt = ram_wdata;
                end else begin
                  res_status_nxt = ST_EARLIER;
                end
              end
            end
            MODE_ABORT: begin
              if (!hit) begin
                res_status_nxt = ST_BAD_USER;
              end else begin
                abort_re  = 1'b1;
                state_nxt = S_ABORT_EVAL;
              end
            end
            MODE_SET_CLOCK: begin
              if (allowed_r[user_r]) begin
                clock_nxt = tv_r;
              end else begin
                res_status_nxt = ST_NOT_OK;
              end
            end
            MODE_GET_CLOCK:  res_time_nxt = clock_r;
            MODE_GET_WAKEUP: res_time_nxt = master_r;
            default: begin
              valid_nxt  = '0;
              master_nxt = TIME_ALL_ONES;
            end
          endcase
        end
      end
      S_ABORT_EVAL: begin
        state_nxt = S_DONE;
        if (slot_value == '0) begin
          res_status_nxt = ST_NOT_OK;
        end else begin
          valid_nxt[slot_r] = 1'b0;
          if (slot_value == master_r) begin
            scan_req.start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_rsp.done) begin
          master_nxt = scan_rsp.best;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (state_r == S_DONE) ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clock_r     <= '0;
      master_r    <= TIME_ALL_ONES;
      ms_r        <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      master_r    <= master_nxt;
      ms_r        <= ms_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      user_r <= in_user;
      tv_r   <= in_time_value;
    end
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_time_r   <= res_time_nxt;
    res_fired_r  <= res_fired_nxt;
    if (state_r == S_DONE && out_load) begin
      out_status_r <= res_status_r;
      out_time_r   <= res_time_r;
      out_fired_r  <= res_fired_r;
    end
  end

  assign ram_re    = scan_re || abort_re;
  assign ram_raddr = scan_re ? scan_addr : hit_idx;

  mualm_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_ALARMS),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mualm_scan #(
    .NUM_ALARMS (NUM_ALARMS),
    .IDX_W      (IDX_W)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (scan_req),
    .slot_valid (valid_r),
    .rdata      (ram_rdata),
    .rd_en      (scan_re),
    .rd_addr    (scan_addr),
    .rsp        (scan_rsp)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_time_out    = out_time_r;
  assign out_alarm_fired = out_fired_r;

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_rsp.done |-> state_r == S_SCAN)
    else $error("slot walk finished outside the scan state");

  a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !ram_we && !abort_re)
    else $error("slot memory accessed by control during the slot walk");

  a_fired_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fired_r |-> out_status_r == ST_OK)
    else $error("fired item reports a status other than ok");

  a_time_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_time_r != '0 |-> out_status_r == ST_OK && !out_fired_r)
    else $error("nonzero time on an item that is not a successful read");

endmodule

// ----- sv/mualm_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module mualm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/mualm_scan.sv -----
// Sequential walk over the slot memory that finds the next master alarm.
module mualm_scan #(
  parameter int NUM_ALARMS = mualm_pkg::NUM_ALARMS_DEF,
  parameter int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mualm_pkg::scan_req_t                 req,
  input  logic [NUM_ALARMS-1:0]                slot_valid,
  input  logic [mualm_pkg::TIME_W-1:0]         rdata,
  output logic                                 rd_en,
  output logic [IDX_W-1:0]                     rd_addr,
  output mualm_pkg::scan_rsp_t                 rsp
);
  import mualm_pkg::*;

  localparam int CNT_W = $clog2(NUM_ALARMS + 1);

  logic              busy_r, busy_nxt;
  logic              pend_r, pend_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [TIME_W-1:0] best_r, best_nxt;
  logic [TIME_W-1:0] retire_r, retire_nxt;
  logic [TIME_W-1:0] value;

  assign value = slot_valid[idx_r] ? rdata : '0;

  always_comb begin
    busy_nxt   = busy_r;
    pend_nxt   = pend_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    best_nxt   = best_r;
    retire_nxt = retire_r;
    rd_en      = 1'b0;
    rd_addr    = cnt_r[IDX_W-1:0];
    if (req.start) begin
      busy_nxt   = 1'b1;
      pend_nxt   = 1'b0;
      cnt_nxt    = '0;
      best_nxt   = TIME_ALL_ONES;
      retire_nxt = req.retiring;
    end else if (busy_r) begin
      if (pend_r && value != '0 && value > retire_r && value < best_r) begin
        best_nxt = value;
      end
      if (cnt_r < CNT_W'(NUM_ALARMS)) begin
        rd_en    = 1'b1;
        pend_nxt = 1'b1;
        idx_nxt  = cnt_r[IDX_W-1:0];
        cnt_nxt  = cnt_r + 1'b1;
      end else begin
        pend_nxt = 1'b0;
        if (!pend_r) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    idx_r    <= idx_nxt;
    best_r   <= best_nxt;
    retire_r <= retire_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.best = best_r;

endmodule
